// ===== rtl/ddvc_pkg.sv =====
package ddvc_pkg;

    // datapath widths
    localparam int DVD_W  = 30;   // dividend and quotient magnitude
    localparam int DVS_W  = 17;   // divisor magnitude
    localparam int MUL_A_W = 17;
    localparam int MUL_B_W = 16;
    localparam int CNT_W  = $clog2(DVD_W);
    localparam int STEP_W = 5;

    typedef logic [3:0]        op_t;
    typedef logic [2:0]        cond_t;
    typedef logic [2:0]        dst_t;
    typedef logic [STEP_W-1:0] step_t;

    // one microcode word
    typedef struct packed {
        op_t   op;
        cond_t cond;
        step_t target;
        dst_t  dst;
    } ctrl_t;

    // datapath operations
    localparam op_t OP_NOP       = 4'd0;
    localparam op_t OP_MUL_FWD   = 4'd1;
    localparam op_t OP_MUL_TRE   = 4'd2;
    localparam op_t OP_MUL_HALF  = 4'd3;
    localparam op_t OP_MUL_LEFT  = 4'd4;
    localparam op_t OP_MUL_RIGHT = 4'd5;
    localparam op_t OP_DIV_T     = 4'd6;
    localparam op_t OP_DIV_M     = 4'd7;
    localparam op_t OP_DIV_B     = 4'd8;
    localparam op_t OP_TURN      = 4'd9;
    localparam op_t OP_MAN       = 4'd10;
    localparam op_t OP_HALF      = 4'd11;
    localparam op_t OP_MAX       = 4'd12;
    localparam op_t OP_SUMS      = 4'd13;
    localparam op_t OP_EMIT      = 4'd14;

    // jump conditions
    localparam cond_t C_NONE   = 3'd0;
    localparam cond_t C_ALWAYS = 3'd1;
    localparam cond_t C_MANUAL = 3'd2;
    localparam cond_t C_BIG    = 3'd3;
    localparam cond_t C_FIT    = 3'd4;

    // quotient destinations
    localparam dst_t DST_NONE   = 3'd0;
    localparam dst_t DST_LIN    = 3'd1;
    localparam dst_t DST_ANG    = 3'd2;
    localparam dst_t DST_LEFT   = 3'd3;
    localparam dst_t DST_RIGHT  = 3'd4;
    localparam dst_t DST_ANGSAT = 3'd5;

    // program steps
    localparam step_t S_START    = 5'd0;
    localparam step_t S_CHECK    = 5'd1;
    localparam step_t S_FWD_MUL  = 5'd2;
    localparam step_t S_FWD_DIV  = 5'd3;
    localparam step_t S_TRE_MUL  = 5'd4;
    localparam step_t S_TRE_DIV  = 5'd5;
    localparam step_t S_TURN     = 5'd6;
    localparam step_t S_MAN      = 5'd7;
    localparam step_t S_WHEEL    = 5'd8;
    localparam step_t S_HALF     = 5'd9;
    localparam step_t S_MAX      = 5'd10;
    localparam step_t S_LMUL     = 5'd11;
    localparam step_t S_LDIV     = 5'd12;
    localparam step_t S_RMUL     = 5'd13;
    localparam step_t S_RDIV     = 5'd14;
    localparam step_t S_SUM      = 5'd15;
    localparam step_t S_ANG_DIV  = 5'd16;
    localparam step_t S_EMIT     = 5'd17;

    // manual direction codes
    localparam logic [2:0] DIR_FRONT = 3'd0;
    localparam logic [2:0] DIR_BACK  = 3'd1;
    localparam logic [2:0] DIR_LEFT  = 3'd2;
    localparam logic [2:0] DIR_RIGHT = 3'd3;
    localparam logic [2:0] DIR_STOP  = 3'd4;

endpackage

// ===== rtl/ddvc_div.sv =====
module ddvc_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [ddvc_pkg::DVD_W-1:0]  dividend,
    input  logic [ddvc_pkg::DVS_W-1:0]  divisor,
    output logic                        done,
    output logic [ddvc_pkg::DVD_W-1:0]  quotient
);

    logic [ddvc_pkg::DVS_W-1:0] rem_reg, rem_next;
    logic [ddvc_pkg::DVD_W-1:0] quo_reg, quo_next;
    logic [ddvc_pkg::DVS_W-1:0] dvs_reg, dvs_next;
    logic [ddvc_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic                       busy_reg, busy_next;
    logic                       done_reg, done_next;
    logic [ddvc_pkg::DVS_W:0]   trial;
    logic [ddvc_pkg::DVS_W:0]   trial_sub;
    logic                       fits;

    // one restoring step: shift in the next dividend bit and try to subtract
    assign trial     = {rem_reg, quo_reg[ddvc_pkg::DVD_W-1]};
    assign trial_sub = trial - {1'b0, dvs_reg};
    assign fits      = trial >= {1'b0, dvs_reg};

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
            cnt_next  = ddvc_pkg::CNT_W'(ddvc_pkg::DVD_W - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? trial_sub[ddvc_pkg::DVS_W-1:0] : trial[ddvc_pkg::DVS_W-1:0];
            quo_next = {quo_reg[ddvc_pkg::DVD_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
        cnt_reg <= cnt_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== rtl/ddvc_rom.sv =====
module ddvc_rom (
    input  ddvc_pkg::step_t step,
    output ddvc_pkg::ctrl_t ctrl
);

    // microprogram: follow branch, manual branch, wheel limiting, recompute
    always_comb
    begin
        unique case (step)
            ddvc_pkg::S_START:   ctrl = '{ddvc_pkg::OP_NOP, ddvc_pkg::C_MANUAL,
                                          ddvc_pkg::S_MAN, ddvc_pkg::DST_NONE};
            ddvc_pkg::S_CHECK:   ctrl = '{ddvc_pkg::OP_NOP, ddvc_pkg::C_BIG,
                                          ddvc_pkg::S_TURN, ddvc_pkg::DST_NONE};
            ddvc_pkg::S_FWD_MUL: ctrl = '{ddvc_pkg::OP_MUL_FWD, ddvc_pkg::C_NONE,
                                          ddvc_pkg::S_START, ddvc_pkg::DST_NONE};
            ddvc_pkg::S_FWD_DIV: ctrl = '{ddvc_pkg::OP_DIV_T, ddvc_pkg::C_NONE,
                                          ddvc_pkg::S_START, ddvc_pkg::DST_LIN};
            ddvc_pkg::S_TRE_MUL: ctrl = '{ddvc_pkg::OP_MUL_TRE, ddvc_pkg::C_NONE,
                                          ddvc_pkg::S_START, ddvc_pkg::DST_NONE};
            ddvc_pkg::S_TRE_DIV: ctrl = '{ddvc_pkg::OP_DIV_T, ddvc_pkg::C_ALWAYS,
                                          ddvc_pkg::S_WHEEL, ddvc_pkg::DST_ANG};
            ddvc_pkg::S_TURN:    ctrl = '{ddvc_pkg::OP_TURN, ddvc_pkg::C_ALWAYS,
                                          ddvc_pkg::S_WHEEL, ddvc_pkg::DST_NONE};
            ddvc_pkg::S_MAN:     ctrl = '{ddvc_pkg::OP_MAN, ddvc_pkg::C_NONE,
                                          ddvc_pkg::S_START, ddvc_pkg::DST_NONE};
            ddvc_pkg::S_WHEEL:   ctrl = '{ddvc_pkg::OP_MUL_HALF, ddvc_pkg::C_NONE,
                                          ddvc_pkg::S_START, ddvc_pkg::DST_NONE};
            ddvc_pkg::S_HALF:    ctrl = '{ddvc_pkg::OP_HALF, ddvc_pkg::C_NONE,
                                          ddvc_pkg::S_START, ddvc_pkg::DST_NONE};
            ddvc_pkg::S_MAX:     ctrl = '{ddvc_pkg::OP_MAX, ddvc_pkg::C_FIT,
                                          ddvc_pkg::S_SUM, ddvc_pkg::DST_NONE};
            ddvc_pkg::S_LMUL:    ctrl = '{ddvc_pkg::OP_MUL_LEFT, ddvc_pkg::C_NONE,
                                          ddvc_pkg::S_START, ddvc_pkg::DST_NONE};
            ddvc_pkg::S_LDIV:    ctrl = '{ddvc_pkg::OP_DIV_M, ddvc_pkg::C_NONE,
                                          ddvc_pkg::S_START, ddvc_pkg::DST_LEFT};
            ddvc_pkg::S_RMUL:    ctrl = '{ddvc_pkg::OP_MUL_RIGHT, ddvc_pkg::C_NONE,
                                          ddvc_pkg::S_START, ddvc_pkg::DST_NONE};
            ddvc_pkg::S_RDIV:    ctrl = '{ddvc_pkg::OP_DIV_M, ddvc_pkg::C_NONE,
                                          ddvc_pkg::S_START, ddvc_pkg::DST_RIGHT};
            ddvc_pkg::S_SUM:     ctrl = '{ddvc_pkg::OP_SUMS, ddvc_pkg::C_NONE,
                                          ddvc_pkg::S_START, ddvc_pkg::DST_NONE};
            ddvc_pkg::S_ANG_DIV: ctrl = '{ddvc_pkg::OP_DIV_B, ddvc_pkg::C_NONE,
                                          ddvc_pkg::S_START, ddvc_pkg::DST_ANGSAT};
            ddvc_pkg::S_EMIT:    ctrl = '{ddvc_pkg::OP_EMIT, ddvc_pkg::C_NONE,
                                          ddvc_pkg::S_START, ddvc_pkg::DST_NONE};
            default:             ctrl = '{ddvc_pkg::OP_EMIT, ddvc_pkg::C_NONE,
                                          ddvc_pkg::S_START, ddvc_pkg::DST_NONE};
        endcase
    end

endmodule

// ===== rtl/diff_drive_velocity_command.sv =====
// Differential-drive velocity command. Each input item is a heading error to
// follow or a manual direction; each gives exactly one result item with the
// corrected linear and angular velocity, both wheel speeds and a flag telling
// whether the wheels were scaled down to wheel_limit. Velocities from the last
// item are kept, and the auto direction reuses them. One item is processed at
// a time by a microcoded sequencer over a shared multiplier and a one bit per
// cycle divider; every division holds its step until the divider is done. A
// finished result sits in an output register, so the next item is taken while
// it waits. Registers are written over the APB port at byte addresses 0, 4, 8,
// 12, 16 and read back there.
module diff_drive_velocity_command (
    input  logic               clk,
    input  logic               rst_n,
    // configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    // command items
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               req_type,
    input  logic signed [16:0] heading_error,
    input  logic [2:0]         direction,
    // result items
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [13:0] lin_vel,
    output logic signed [15:0] ang_vel,
    output logic signed [13:0] left_wheel,
    output logic signed [13:0] right_wheel,
    output logic               was_limited
);

    localparam logic [2:0]  REG_THR = 3'd0;
    localparam logic [2:0]  REG_FWD = 3'd1;
    localparam logic [2:0]  REG_TRN = 3'd2;
    localparam logic [2:0]  REG_WB  = 3'd3;
    localparam logic [2:0]  REG_LIM = 3'd4;
    localparam logic [15:0] ANG_POS_MAX = 16'h7FFF;
    localparam logic [15:0] ANG_NEG_MAX = 16'h8000;
    localparam logic [ddvc_pkg::DVD_W-1:0] ANG_POS_LIM = 30'd32767;
    localparam logic [ddvc_pkg::DVD_W-1:0] ANG_NEG_LIM = 30'd32768;

    // configuration registers
    logic [15:0] thr_reg;
    logic [12:0] fwd_reg;
    logic [12:0] trn_reg;
    logic [13:0] wb_reg;
    logic [12:0] lim_reg;
    logic        cfg_wr;

    // sequencer
    ddvc_pkg::step_t step_reg, step_next;
    ddvc_pkg::ctrl_t ctrl;
    logic            busy_reg, busy_next;
    logic            wait_reg, wait_next;
    logic            in_take;
    logic            is_div;
    logic            hold;
    logic            jump;
    logic            emit;

    // captured item
    logic        typ_reg;
    logic [16:0] e_reg;
    logic [2:0]  dir_reg;

    // datapath registers
    logic [13:0]                lin_reg, lin_next;
    logic [15:0]                ang_reg, ang_next;
    logic [17:0]                left_reg, left_next;
    logic [17:0]                right_reg, right_next;
    logic [16:0]                mag_reg, mag_next;
    logic [ddvc_pkg::DVD_W-1:0] prod_reg, prod_next;
    logic                       sgn_reg, sgn_next;
    logic                       limd_reg, limd_next;

    // output slot
    logic        out_valid_reg, out_valid_next;
    logic [13:0] lin_out_reg;
    logic [15:0] ang_out_reg;
    logic [13:0] left_out_reg;
    logic [13:0] right_out_reg;
    logic        limd_out_reg;

    // datapath combinational values
    logic [15:0] t_eff;
    logic [13:0] b_eff;
    logic        e_neg;
    logic [16:0] e_negv;
    logic [16:0] ae;
    logic        big;
    logic [16:0] ang_negv;
    logic [16:0] ang_abs;
    logic [17:0] left_negv;
    logic [17:0] right_negv;
    logic [16:0] left_abs;
    logic [16:0] right_abs;
    logic [16:0] m_val;
    logic        over;
    logic [16:0] half_mag;
    logic [17:0] half_val;
    logic [17:0] lin_ext;
    logic [18:0] sum_val;
    logic [18:0] sum_negv;
    logic [17:0] sum_abs;
    logic [13:0] sum_half;
    logic [18:0] diff_val;
    logic [18:0] diff_negv;
    logic [17:0] diff_abs;
    logic [ddvc_pkg::MUL_A_W-1:0] mul_a;
    logic [ddvc_pkg::MUL_B_W-1:0] mul_b;
    logic [ddvc_pkg::MUL_A_W+ddvc_pkg::MUL_B_W-1:0] mul_p;
    logic                         div_start;
    logic                         div_done;
    logic [ddvc_pkg::DVS_W-1:0]   div_dvs;
    logic [ddvc_pkg::DVD_W-1:0]   div_q;
    logic [ddvc_pkg::DVD_W:0]     q_negv;
    logic [ddvc_pkg::DVD_W:0]     q_s;
    logic [15:0]                  q_sat;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= 16'd2560;
            fwd_reg <= 13'd2048;
            trn_reg <= 13'd2048;
            wb_reg  <= 14'd1556;
            lim_reg <= 13'd2048;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[4:2])
                REG_THR: thr_reg <= pwdata[15:0];
                REG_FWD: fwd_reg <= pwdata[12:0];
                REG_TRN: trn_reg <= pwdata[12:0];
                REG_WB:  wb_reg  <= pwdata[13:0];
                REG_LIM: lim_reg <= pwdata[12:0];
                default: ;
            endcase
        end
    end

    // register read back
    always_comb
    begin
        unique case (paddr[4:2])
            REG_THR: prdata = {16'd0, thr_reg};
            REG_FWD: prdata = {19'd0, fwd_reg};
            REG_TRN: prdata = {19'd0, trn_reg};
            REG_WB:  prdata = {18'd0, wb_reg};
            REG_LIM: prdata = {19'd0, lim_reg};
            default: prdata = '0;
        endcase
    end

    // microcode lookup and divider
    ddvc_rom u_rom (
        .step (step_reg),
        .ctrl (ctrl)
    );

    ddvc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (prod_reg),
        .divisor  (div_dvs),
        .done     (div_done),
        .quotient (div_q)
    );

    // operand preparation
    assign t_eff    = (thr_reg == '0) ? 16'd1 : thr_reg;
    assign b_eff    = (wb_reg == '0) ? 14'd1 : wb_reg;
    assign e_neg    = e_reg[16];
    assign e_negv   = 17'd0 - e_reg;
    assign ae       = e_neg ? e_negv : e_reg;
    assign big      = ae > {1'b0, t_eff};
    assign ang_negv = 17'd0 - {ang_reg[15], ang_reg};
    assign ang_abs  = ang_reg[15] ? ang_negv : {1'b0, ang_reg};
    assign left_negv  = 18'd0 - left_reg;
    assign right_negv = 18'd0 - right_reg;
    assign left_abs   = left_reg[17] ? left_negv[16:0] : left_reg[16:0];
    assign right_abs  = right_reg[17] ? right_negv[16:0] : right_reg[16:0];
    assign m_val      = (left_abs > right_abs) ? left_abs : right_abs;
    assign over       = m_val > {4'd0, lim_reg};

    // half of the wheel speed difference, truncated toward zero
    assign half_mag = prod_reg[29:13];
    assign half_val = sgn_reg ? (18'd0 - {1'b0, half_mag}) : {1'b0, half_mag};
    assign lin_ext  = {{4{lin_reg[13]}}, lin_reg};

    // wheel sum and difference for the recomputed velocities
    assign sum_val   = {left_reg[17], left_reg} + {right_reg[17], right_reg};
    assign sum_negv  = 19'd0 - sum_val;
    assign sum_abs   = sum_val[18] ? sum_negv[17:0] : sum_val[17:0];
    assign sum_half  = sum_abs[14:1];
    assign diff_val  = {right_reg[17], right_reg} - {left_reg[17], left_reg};
    assign diff_negv = 19'd0 - diff_val;
    assign diff_abs  = diff_val[18] ? diff_negv[17:0] : diff_val[17:0];

    // shared multiplier operand select
    always_comb
    begin
        unique case (ctrl.op)
            ddvc_pkg::OP_MUL_FWD:
            begin
                mul_a = {1'b0, t_eff} - ae;
                mul_b = {3'd0, fwd_reg};
            end
            ddvc_pkg::OP_MUL_TRE:
            begin
                mul_a = ae;
                mul_b = {3'd0, trn_reg};
            end
            ddvc_pkg::OP_MUL_HALF:
            begin
                mul_a = ang_abs;
                mul_b = {2'd0, b_eff};
            end
            ddvc_pkg::OP_MUL_LEFT:
            begin
                mul_a = left_abs;
                mul_b = {3'd0, lim_reg};
            end
            ddvc_pkg::OP_MUL_RIGHT:
            begin
                mul_a = right_abs;
                mul_b = {3'd0, lim_reg};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = {{ddvc_pkg::MUL_B_W{1'b0}}, mul_a} * {{ddvc_pkg::MUL_A_W{1'b0}}, mul_b};

    // divisor select
    always_comb
    begin
        unique case (ctrl.op)
            ddvc_pkg::OP_DIV_T: div_dvs = {1'b0, t_eff};
            ddvc_pkg::OP_DIV_M: div_dvs = mag_reg;
            ddvc_pkg::OP_DIV_B: div_dvs = {3'd0, b_eff};
            default:            div_dvs = '0;
        endcase
    end

    // signed quotient and saturated angular value
    assign q_negv = {(ddvc_pkg::DVD_W+1){1'b0}} - {1'b0, div_q};
    assign q_s    = sgn_reg ? q_negv : {1'b0, div_q};

    always_comb
    begin
        priority if (!sgn_reg && (div_q > ANG_POS_LIM))
            q_sat = ANG_POS_MAX;
        else if (sgn_reg && (div_q > ANG_NEG_LIM))
            q_sat = ANG_NEG_MAX;
        else
            q_sat = q_s[15:0];
    end

    // sequencer control
    assign in_stall  = busy_reg;
    assign in_take   = in_valid && !busy_reg;
    assign is_div    = (ctrl.op == ddvc_pkg::OP_DIV_T) || (ctrl.op == ddvc_pkg::OP_DIV_M) ||
                       (ctrl.op == ddvc_pkg::OP_DIV_B);
    assign div_start = busy_reg && is_div && !wait_reg;
    assign emit      = busy_reg && (ctrl.op == ddvc_pkg::OP_EMIT) &&
                       (!out_valid_reg || !out_stall);
    assign hold      = (is_div && !(wait_reg && div_done)) ||
                       ((ctrl.op == ddvc_pkg::OP_EMIT) && out_valid_reg && out_stall);

    always_comb
    begin
        unique case (ctrl.cond)
            ddvc_pkg::C_NONE:   jump = 1'b0;
            ddvc_pkg::C_ALWAYS: jump = 1'b1;
            ddvc_pkg::C_MANUAL: jump = typ_reg;
            ddvc_pkg::C_BIG:    jump = big;
            ddvc_pkg::C_FIT:    jump = !over;
            default:            jump = 1'b0;
        endcase
    end

    always_comb
    begin
        step_next = step_reg;
        busy_next = busy_reg;
        wait_next = wait_reg;
        if (in_take)
        begin
            step_next = ddvc_pkg::S_START;
            busy_next = 1'b1;
            wait_next = 1'b0;
        end
        else if (busy_reg)
        begin
            if (div_start)
                wait_next = 1'b1;
            else if (is_div && div_done)
                wait_next = 1'b0;
            if (!hold)
            begin
                if (ctrl.op == ddvc_pkg::OP_EMIT)
                    busy_next = 1'b0;
                else if (jump)
                    step_next = ctrl.target;
                else
                    step_next = step_reg + 1'b1;
            end
        end
    end

    // datapath register updates
    always_comb
    begin
        lin_next   = lin_reg;
        ang_next   = ang_reg;
        left_next  = left_reg;
        right_next = right_reg;
        mag_next   = mag_reg;
        prod_next  = prod_reg;
        sgn_next   = sgn_reg;
        limd_next  = limd_reg;
        if (in_take)
            limd_next = 1'b0;
        else if (busy_reg)
        begin
            unique case (ctrl.op)
                ddvc_pkg::OP_MUL_FWD:
                begin
                    prod_next = mul_p[ddvc_pkg::DVD_W-1:0];
                    sgn_next  = 1'b0;
                end
                ddvc_pkg::OP_MUL_TRE:
                begin
                    prod_next = mul_p[ddvc_pkg::DVD_W-1:0];
                    sgn_next  = e_neg;
                end
                ddvc_pkg::OP_MUL_HALF:
                begin
                    prod_next = mul_p[ddvc_pkg::DVD_W-1:0];
                    sgn_next  = ang_reg[15];
                end
                ddvc_pkg::OP_MUL_LEFT:
                begin
                    prod_next = mul_p[ddvc_pkg::DVD_W-1:0];
                    sgn_next  = left_reg[17];
                end
                ddvc_pkg::OP_MUL_RIGHT:
                begin
                    prod_next = mul_p[ddvc_pkg::DVD_W-1:0];
                    sgn_next  = right_reg[17];
                end
                ddvc_pkg::OP_DIV_T, ddvc_pkg::OP_DIV_M, ddvc_pkg::OP_DIV_B:
                begin
                    if (wait_reg && div_done)
                    begin
                        unique case (ctrl.dst)
                            ddvc_pkg::DST_LIN:    lin_next   = q_s[13:0];
                            ddvc_pkg::DST_ANG:    ang_next   = q_s[15:0];
                            ddvc_pkg::DST_LEFT:   left_next  = q_s[17:0];
                            ddvc_pkg::DST_RIGHT:  right_next = q_s[17:0];
                            ddvc_pkg::DST_ANGSAT: ang_next   = q_sat;
                            default: ;
                        endcase
                    end
                end
                ddvc_pkg::OP_TURN:
                begin
                    lin_next = '0;
                    ang_next = e_neg ? (16'd0 - {3'd0, trn_reg}) : {3'd0, trn_reg};
                end
                ddvc_pkg::OP_MAN:
                begin
                    unique case (dir_reg)
                        ddvc_pkg::DIR_FRONT:
                        begin
                            lin_next = {1'b0, fwd_reg};
                            ang_next = '0;
                        end
                        ddvc_pkg::DIR_BACK:
                        begin
                            lin_next = 14'd0 - {1'b0, fwd_reg};
                            ang_next = '0;
                        end
                        ddvc_pkg::DIR_LEFT:
                        begin
                            lin_next = '0;
                            ang_next = {3'd0, trn_reg};
                        end
                        ddvc_pkg::DIR_RIGHT:
                        begin
                            lin_next = '0;
                            ang_next = 16'd0 - {3'd0, trn_reg};
                        end
                        ddvc_pkg::DIR_STOP:
                        begin
                            lin_next = '0;
                            ang_next = '0;
                        end
                        default: ;  // auto and unused codes keep the last velocities
                    endcase
                end
                ddvc_pkg::OP_HALF:
                begin
                    left_next  = lin_ext - half_val;
                    right_next = lin_ext + half_val;
                end
                ddvc_pkg::OP_MAX:
                begin
                    mag_next  = m_val;
                    limd_next = over;
                end
                ddvc_pkg::OP_SUMS:
                begin
                    lin_next  = sum_val[18] ? (14'd0 - sum_half) : sum_half;
                    prod_next = {diff_abs, 12'd0};
                    sgn_next  = diff_val[18];
                end
                default: ;
            endcase
        end
    end

    // output slot handshake
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    // control state and kept velocities
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= ddvc_pkg::S_START;
            busy_reg      <= 1'b0;
            wait_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            lin_reg       <= '0;
            ang_reg       <= '0;
        end
        else
        begin
            step_reg      <= step_next;
            busy_reg      <= busy_next;
            wait_reg      <= wait_next;
            out_valid_reg <= out_valid_next;
            lin_reg       <= lin_next;
            ang_reg       <= ang_next;
        end
    end

    // payload and working registers
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            typ_reg <= req_type;
            e_reg   <= heading_error;
            dir_reg <= direction;
        end
        left_reg  <= left_next;
        right_reg <= right_next;
        mag_reg   <= mag_next;
        prod_reg  <= prod_next;
        sgn_reg   <= sgn_next;
        limd_reg  <= limd_next;
        if (emit)
        begin
            lin_out_reg   <= lin_reg;
            ang_out_reg   <= ang_reg;
            left_out_reg  <= left_reg[13:0];
            right_out_reg <= right_reg[13:0];
            limd_out_reg  <= limd_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign lin_vel     = lin_out_reg;
    assign ang_vel     = ang_out_reg;
    assign left_wheel  = left_out_reg;
    assign right_wheel = right_out_reg;
    assign was_limited = limd_out_reg;

endmodule
